FILE: hdl/mma_pkg.sv
// package: shared widths, codes and control types for the matrix multiply accumulate block
package mma_pkg;

  localparam int DEF_MAX_INNER = 16;
  localparam int DEF_MAX_COLS  = 16;

  localparam int ELEM_W = 16;
  localparam int PROD_W = 32;
  localparam int ACC_W  = 36;
  localparam int ROW_W  = 12;
  localparam int CFG_W  = 13;
  localparam int IDX_W  = 4;
  localparam int SIZE_W = 5;
  localparam int REG_W  = 2;

  localparam logic [REG_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_K = 2'd1;
  localparam logic [REG_W-1:0] REG_COLS_N  = 2'd2;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_STREAM = 1'b1;

  localparam logic [CFG_W-1:0]  ROWS_M_RST  = 13'd16;
  localparam logic [SIZE_W-1:0] INNER_K_RST = 5'd16;
  localparam logic [SIZE_W-1:0] COLS_N_RST  = 5'd16;
  localparam logic [CFG_W-1:0]  ROWS_MAX    = 13'd4096;

  typedef struct packed {
    logic adv;
    logic valid;
    logic close;
  } mma_ctrl_t;

endpackage

FILE: hdl/mma_wmem.sv
// weight table: one element written per word, one full weight row read per word
module mma_wmem #(
  parameter int MAX_INNER = mma_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mma_pkg::DEF_MAX_COLS
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [mma_pkg::IDX_W-1:0]             wr_k_i,
  input  logic [mma_pkg::IDX_W-1:0]             wr_col_i,
  input  logic signed [mma_pkg::ELEM_W-1:0]     wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [mma_pkg::IDX_W-1:0]             rd_k_i,
  output logic signed [mma_pkg::ELEM_W-1:0]     rd_row_o [MAX_COLS]
);
  import mma_pkg::*;

  localparam int KIW = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic signed [ELEM_W-1:0] mem [MAX_COLS][MAX_INNER];
  logic signed [ELEM_W-1:0] rd_row_q [MAX_COLS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[CIW'(wr_col_i)][KIW'(wr_k_i)] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        rd_row_q[j] <= mem[j][KIW'(rd_k_i)];
      end
    end
  end

  assign rd_row_o = rd_row_q;

endmodule

FILE: hdl/mma_mac.sv
// multiply lanes and column accumulators, one lane per output column
module mma_mac #(
  parameter int MAX_COLS = mma_pkg::DEF_MAX_COLS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mma_pkg::mma_ctrl_t                 ctrl_i,
  input  logic signed [mma_pkg::ELEM_W-1:0]  elem_i,
  input  logic signed [mma_pkg::ELEM_W-1:0]  wrow_i [MAX_COLS],
  input  logic [mma_pkg::SIZE_W-1:0]         nn_i,
  output logic                               done_o,
  output logic signed [mma_pkg::ACC_W-1:0]   sum_o [MAX_COLS]
);
  import mma_pkg::*;

  logic                     s2_v_q, s2_close_q;
  logic signed [PROD_W-1:0] prod_q [MAX_COLS];
  logic signed [ACC_W-1:0]  acc_q [MAX_COLS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q     <= 1'b0;
      s2_close_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      s2_v_q     <= ctrl_i.valid;
      s2_close_q <= ctrl_i.close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        prod_q[j] <= elem_i * wrow_i[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      sum_o[j] = acc_q[j] + ACC_W'(prod_q[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        acc_q[j] <= '0;
      end
    end else if (ctrl_i.adv && s2_v_q) begin
      for (int j = 0; j < MAX_COLS; j++) begin
        if (s2_close_q) begin
          acc_q[j] <= '0;
        end else if (int'(nn_i) > j) begin
          acc_q[j] <= sum_o[j];
        end
      end
    end
  end

  assign done_o = s2_v_q && s2_close_q;

endmodule

FILE: hdl/mma_obuf.sv
// result buffer: holds one finished row and sends it one column word at a time
module mma_obuf #(
  parameter int MAX_COLS = mma_pkg::DEF_MAX_COLS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               load_i,
  input  logic signed [mma_pkg::ACC_W-1:0]   sum_i [MAX_COLS],
  input  logic [mma_pkg::ROW_W-1:0]          row_i,
  input  logic [mma_pkg::SIZE_W-1:0]         nn_i,
  output logic                               busy_o,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mma_pkg::ROW_W-1:0]          row_index_o,
  output logic [mma_pkg::IDX_W-1:0]          out_col_o,
  output logic signed [mma_pkg::ACC_W-1:0]   sum_value_o,
  output logic                               last_o
);
  import mma_pkg::*;

  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  logic signed [ACC_W-1:0] buf_q [MAX_COLS];
  logic [ROW_W-1:0]        row_q;
  logic [CIW-1:0]          idx_q, idx_d, last_idx_q;
  logic                    busy_q, busy_d;
  logic                    take;

  assign take = busy_q && !out_stall_i;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (load_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (take) begin
      if (idx_q == last_idx_q) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q      <= sum_i;
      row_q      <= row_i;
      last_idx_q <= CIW'(nn_i - 5'd1);
    end
  end

  assign busy_o      = busy_q;
  assign out_valid_o = busy_q;
  assign row_index_o = row_q;
  assign out_col_o   = IDX_W'(idx_q);
  assign sum_value_o = buf_q[idx_q];
  assign last_o      = (idx_q == last_idx_q);

endmodule

FILE: hdl/matrix_multiply_accumulate_top.sv
// top level: matrix multiply accumulate with weight table, mac lanes and result buffer
//
//   channel  direction  handshake                 payload
//   in       to block   in_valid_i / in_stall_o   req_type, k_index, col_index, elem_value
//   out      from block out_valid_o / out_stall_i row_index, out_col, sum_value, last
//   cfg      to block   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// one input word per cycle while in_stall_o is low; a stream word passes the element and
// weight row registers and then the product registers before it reaches the accumulators
// a finished row leaves the result buffer one column word per cycle while out_stall_i is low
// the input stalls only while a row is finished and the buffer still holds the previous row
// reset clears control, accumulators and row counter and sets the size registers to 16; the weight table is not reset
module matrix_multiply_accumulate_top #(
  parameter int MAX_INNER = mma_pkg::DEF_MAX_INNER,
  parameter int MAX_COLS  = mma_pkg::DEF_MAX_COLS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mma_pkg::REG_W-1:0]          cfg_idx_i,
  input  logic [mma_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               req_type_i,
  input  logic [mma_pkg::IDX_W-1:0]          k_index_i,
  input  logic [mma_pkg::IDX_W-1:0]          col_index_i,
  input  logic signed [mma_pkg::ELEM_W-1:0]  elem_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mma_pkg::ROW_W-1:0]          row_index_o,
  output logic [mma_pkg::IDX_W-1:0]          out_col_o,
  output logic signed [mma_pkg::ACC_W-1:0]   sum_value_o,
  output logic                               last_o
);
  import mma_pkg::*;

  logic [CFG_W-1:0]  rows_m_q;
  logic [SIZE_W-1:0] inner_k_q, cols_n_q;
  logic [SIZE_W-1:0] kk, nn;
  logic [CFG_W-1:0]  rows_lim, row_inc;
  logic [ROW_W-1:0]  row_q, row_d;

  logic accept, in_k_ok, wr_en, rd_en, hold, done, busy, row_load;
  logic s1_v_q, s1_close_q;
  logic signed [ELEM_W-1:0] elem_q;
  logic signed [ELEM_W-1:0] wrow [MAX_COLS];
  logic signed [ACC_W-1:0]  sums [MAX_COLS];
  mma_ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_m_q  <= ROWS_M_RST;
      inner_k_q <= INNER_K_RST;
      cols_n_q  <= COLS_N_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS_M:  rows_m_q  <= cfg_data_i;
        REG_INNER_K: inner_k_q <= cfg_data_i[SIZE_W-1:0];
        REG_COLS_N:  cols_n_q  <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  always_comb begin
    kk = inner_k_q;
    if (inner_k_q == '0) begin
      kk = 5'd1;
    end else if (int'(inner_k_q) > MAX_INNER) begin
      kk = SIZE_W'(MAX_INNER);
    end
    nn = cols_n_q;
    if (cols_n_q == '0) begin
      nn = 5'd1;
    end else if (int'(cols_n_q) > MAX_COLS) begin
      nn = SIZE_W'(MAX_COLS);
    end
    rows_lim = ((rows_m_q == '0) || (rows_m_q > ROWS_MAX)) ? ROWS_MAX : rows_m_q;
  end

  assign hold       = done && busy;
  assign in_stall_o = hold;
  assign accept     = in_valid_i && !hold;
  assign in_k_ok    = {1'b0, k_index_i} < kk;
  assign wr_en      = accept && (req_type_i == REQ_LOAD) && in_k_ok &&
                      ({1'b0, col_index_i} < nn);
  assign rd_en      = accept && (req_type_i == REQ_STREAM) && in_k_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q     <= 1'b0;
      s1_close_q <= 1'b0;
    end else if (!hold) begin
      s1_v_q     <= rd_en;
      s1_close_q <= ({1'b0, k_index_i} == kk - 5'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      elem_q <= elem_value_i;
    end
  end

  assign ctrl.adv   = !hold;
  assign ctrl.valid = s1_v_q;
  assign ctrl.close = s1_close_q;

  // row counter, wraps at the row limit
  assign row_load = done && !busy;
  assign row_inc  = {1'b0, row_q} + 13'd1;
  assign row_d    = (row_inc >= rows_lim) ? '0 : row_inc[ROW_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (row_load) begin
      row_q <= row_d;
    end
  end

  mma_wmem #(
    .MAX_INNER (MAX_INNER),
    .MAX_COLS  (MAX_COLS)
  ) u_wmem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_k_i    (k_index_i),
    .wr_col_i  (col_index_i),
    .wr_data_i (elem_value_i),
    .rd_en_i   (rd_en),
    .rd_k_i    (k_index_i),
    .rd_row_o  (wrow)
  );

  mma_mac #(
    .MAX_COLS (MAX_COLS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .elem_i (elem_q),
    .wrow_i (wrow),
    .nn_i   (nn),
    .done_o (done),
    .sum_o  (sums)
  );

  mma_obuf #(
    .MAX_COLS (MAX_COLS)
  ) u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (row_load),
    .sum_i       (sums),
    .row_i       (row_q),
    .nn_i        (nn),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_index_o (row_index_o),
    .out_col_o   (out_col_o),
    .sum_value_o (sum_value_o),
    .last_o      (last_o)
  );

endmodule

FILE: hdl/mma_chk.sv
// port checker for the matrix multiply accumulate top level, with its bind
module mma_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [mma_pkg::ROW_W-1:0]          row_index_o,
  input logic [mma_pkg::IDX_W-1:0]          out_col_o,
  input logic signed [mma_pkg::ACC_W-1:0]   sum_value_o,
  input logic                               last_o
);
  import mma_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(row_index_o) &&
      $stable(out_col_o) && $stable(sum_value_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // columns of a row follow in order under one row number
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o &&
      (out_col_o == $past(out_col_o) + 4'd1) && $stable(row_index_o))
    else $error("column sequence broken inside a row");

  // a row starts at column zero
  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_col_o == '0))
    else $error("row did not start at column zero");

  // the buffer empties after the last word of a row
  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_o |=> !out_valid_o)
    else $error("word sent after the last column of a row");

endmodule

bind matrix_multiply_accumulate_top mma_chk u_mma_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .row_index_o (row_index_o),
  .out_col_o   (out_col_o),
  .sum_value_o (sum_value_o),
  .last_o      (last_o)
);
